>>> src/arsp_pkg.sv
package arsp_pkg;

  localparam int REGIONS_DEF       = 4;
  localparam int MAX_INTERVALS_DEF = 64;

  localparam logic [0:0] OP_PLACE = 1'b0;
  localparam logic [0:0] OP_CLEAR = 1'b1;

  localparam logic [2:0] ST_PLACED     = 3'd0;
  localparam logic [2:0] ST_MISALIGNED = 3'd1;
  localparam logic [2:0] ST_OUTSIDE    = 3'd2;
  localparam logic [2:0] ST_OVERLAP    = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  localparam logic [0:0] CFG_SEL_ORIGIN = 1'b0;
  localparam logic [0:0] CFG_SEL_LENGTH = 1'b1;

  localparam logic [17:0] ADDR_TOP       = 18'h10000;
  localparam logic [15:0] ORIGIN_RESET   = 16'd0;
  localparam logic [16:0] LENGTH_RESET   = 17'd1;

  typedef struct packed {
    logic [0:0]  op;
    logic [1:0]  region_sel;
    logic        is_fixed;
    logic [15:0] fixed_addr;
    logic [3:0]  align_log2;
    logic [16:0] section_size;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] placed_addr;
    logic [16:0] placed_end;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  region;
    logic [15:0] lo;
    logic [16:0] hi;
  } ivl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

>>> src/arsp_ram.sv
module arsp_ram import arsp_pkg::*; #(
  parameter int WIDTH = 35,
  parameter int DEPTH = MAX_INTERVALS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/arsp_scan.sv
module arsp_scan import arsp_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1),
  localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] count,
  input  logic [1:0]       probe_region,
  input  logic [16:0]      probe_lo,
  input  logic [17:0]      probe_hi,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  ivl_t             rd_data,
  output scan_res_t        res
);

  logic             busy_r, busy_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             hit_c;

  assign hit_c = (rd_data.region == probe_region) &&
                 (probe_lo < rd_data.hi) &&
                 ({2'b00, rd_data.lo} < probe_hi);

  assign rd_addr = ptr_r[IDX_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = 1'b0;
    ptr_nxt  = ptr_r;
    rd_en    = 1'b0;
    res      = '0;
    if (start) begin
      busy_nxt = 1'b1;
      ptr_nxt  = '0;
    end else if (busy_r) begin
      if (pend_r && hit_c) begin
        res.done = 1'b1;
        res.hit  = 1'b1;
        busy_nxt = 1'b0;
      end else if (ptr_r < count) begin
        rd_en    = 1'b1;
        ptr_nxt  = ptr_r + CNT_W'(1);
        pend_nxt = 1'b1;
      end else begin
        res.done = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      ptr_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

endmodule

>>> src/aligned_region_section_placer.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_word (in_word_t)
// out      output     out_valid / out_stall out_word (out_word_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A clear goes straight to the finish state; a place passes the align and bound states.
// A place rejected there or of zero size then finishes; a nonzero-size place runs the
// overlap scan over the N stored intervals, reading one interval per cycle, and ends
// early on an overlap. At the default depth of 64, at most 64 intervals are scanned.
// Reset empties the store and marks every region untouched.
// A finished word waits in the output register while the next word is taken.
module aligned_region_section_placer import arsp_pkg::*; #(
  parameter int REGIONS       = REGIONS_DEF,
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int IDX_W  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int RIDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_BOUND = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  in_word_t          item_r, item_nxt;
  logic [16:0]       cur_r, cur_nxt;
  logic [16:0]       addr_r, addr_nxt;
  logic [17:0]       end_r, end_nxt;
  logic [2:0]        stat_r, stat_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [REGIONS-1:0] touched_r, touched_nxt;
  logic [16:0]       cursor_r [REGIONS];
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_r, out_nxt;

  logic [15:0]       origin_r [4];
  logic [16:0]       length_r [4];

  logic              in_acc, out_free, scan_start, commit, ram_we;
  logic              r_in;
  logic [RIDX_W-1:0] ridx;
  logic [15:0]       mask;
  logic [16:0]       cursor_c, aligned_c, new_cur;
  logic [17:0]       end_c, lim_c, lim_sum;
  logic              bad_c;
  logic [2:0]        fin_stat;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  ivl_t              rd_data, wr_data;
  scan_res_t         scan_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        origin_r[i] <= ORIGIN_RESET;
        length_r[i] <= LENGTH_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index[0] == CFG_SEL_ORIGIN) begin
        origin_r[cfg_index[2:1]] <= cfg_data[15:0];
      end else begin
        length_r[cfg_index[2:1]] <= cfg_data;
      end
    end
  end

  assign r_in = ({1'b0, item_r.region_sel} < 3'(REGIONS));
  assign ridx = item_r.region_sel[RIDX_W-1:0];
  assign mask = (16'd1 << item_r.align_log2) - 16'd1;

  always_comb begin
    cursor_c = {1'b0, origin_r[item_r.region_sel]};
    if (r_in && touched_r[ridx]) begin
      cursor_c = cursor_r[ridx];
    end
  end

  assign aligned_c = (cursor_c + {1'b0, mask}) & ~{1'b0, mask};
  assign end_c     = {1'b0, addr_r} + {1'b0, item_r.section_size};
  assign lim_sum   = {2'b00, origin_r[item_r.region_sel]} +
                     {1'b0, length_r[item_r.region_sel]};
  assign lim_c     = (lim_sum > ADDR_TOP) ? ADDR_TOP : lim_sum;
  assign bad_c     = (addr_r < {1'b0, origin_r[item_r.region_sel]}) ||
                     (end_c > lim_c) || addr_r[16];

  always_comb begin
    fin_stat = stat_r;
    if (stat_r == ST_PLACED && item_r.op == OP_PLACE &&
        item_r.section_size != '0 && count_r == CNT_W'(MAX_INTERVALS)) begin
      fin_stat = ST_FULL;
    end
  end

  assign new_cur = (end_r[16:0] > cur_r) ? end_r[16:0] : cur_r;
  assign commit  = (state_r == S_FIN) && out_free && (fin_stat == ST_PLACED) &&
                   (item_r.op == OP_PLACE);
  assign ram_we  = commit && (item_r.section_size != '0);

  assign wr_data.region = item_r.region_sel;
  assign wr_data.lo     = addr_r[15:0];
  assign wr_data.hi     = end_r[16:0];

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cur_nxt       = cur_r;
    addr_nxt      = addr_r;
    end_nxt       = end_r;
    stat_nxt      = stat_r;
    count_nxt     = count_r;
    touched_nxt   = touched_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    scan_start    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt = in_word;
          stat_nxt = ST_PLACED;
          addr_nxt = '0;
          end_nxt  = '0;
          if (in_word.op == OP_CLEAR) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_ALIGN;
          end
        end
      end
      S_ALIGN: begin
        cur_nxt  = cursor_c;
        addr_nxt = aligned_c;
        if (!r_in) begin
          stat_nxt = ST_OUTSIDE;
        end else if (item_r.is_fixed) begin
          addr_nxt = {1'b0, item_r.fixed_addr};
          if ((item_r.fixed_addr & mask) != '0) begin
            stat_nxt = ST_MISALIGNED;
          end
        end
        state_nxt = S_BOUND;
      end
      S_BOUND: begin
        end_nxt = end_c;
        if (stat_r == ST_PLACED && bad_c) begin
          stat_nxt  = ST_OUTSIDE;
          state_nxt = S_FIN;
        end else if (stat_r == ST_PLACED && item_r.section_size != '0) begin
          scan_start = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            stat_nxt = ST_OVERLAP;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.status = fin_stat;
          out_nxt.placed_addr = (fin_stat == ST_PLACED) ? addr_r[15:0] : '0;
          out_nxt.placed_end  = (fin_stat == ST_PLACED) ? end_r[16:0] : '0;
          if (item_r.op == OP_CLEAR) begin
            touched_nxt = '0;
            count_nxt   = '0;
          end else if (commit) begin
            touched_nxt[ridx] = 1'b1;
            if (ram_we) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      touched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      touched_r   <= touched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    cur_r  <= cur_nxt;
    addr_r <= addr_nxt;
    end_r  <= end_nxt;
    stat_r <= stat_nxt;
    out_r  <= out_nxt;
    if (commit) begin
      cursor_r[ridx] <= new_cur;
    end
  end

  arsp_scan #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (scan_start),
    .count        (count_r),
    .probe_region (item_r.region_sel),
    .probe_lo     (addr_r),
    .probe_hi     (end_r),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .res          (scan_res)
  );

  arsp_ram #(
    .WIDTH($bits(ivl_t)),
    .DEPTH(MAX_INTERVALS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

>>> src/arsp_checker.sv
module arsp_checker import arsp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again in the cycle after an accept");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == ST_PLACED || out_word.status == ST_MISALIGNED ||
                   out_word.status == ST_OUTSIDE || out_word.status == ST_OVERLAP ||
                   out_word.status == ST_FULL))
    else $error("result status out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_PLACED |->
      out_word.placed_addr == '0 && out_word.placed_end == '0)
    else $error("rejected section carries an address");

  a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_PLACED |->
      out_word.placed_end >= {1'b0, out_word.placed_addr})
    else $error("placed section ends before its start");

endmodule

bind aligned_region_section_placer arsp_checker u_arsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
